// ===== sv/lmpp_pkg.sv =====
// ---------------------------------------------------------------------------
// lmpp_pkg
// Shared types and constants for the list-mode packet parser.
// ---------------------------------------------------------------------------
package lmpp_pkg;

   localparam int WIN_DEPTH   = 44;
   localparam int NUM_WORDS   = WIN_DEPTH / 4;
   localparam int FILL_W      = 6;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      KIND_ERROR    = 4'd0,
      KIND_PULSE    = 4'd1,
      KIND_SYNC     = 4'd2,
      KIND_GATED    = 4'd3,
      KIND_SPATIAL  = 4'd4,
      KIND_POSITION = 4'd5,
      KIND_GATE     = 4'd6,
      KIND_PERIODIC = 4'd7,
      KIND_ANALOG   = 4'd8,
      KIND_OVERFLOW = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_BAD_TYPE = 2'd1,
      CAUSE_BAD_EXT  = 2'd2,
      CAUSE_TAG      = 2'd3
   } cause_type;

   // packet type nibbles
   localparam logic [3:0] TYPE_PULSE    = 4'h0;
   localparam logic [3:0] TYPE_TIME     = 4'h1;
   localparam logic [3:0] TYPE_SYNC     = 4'h8;
   localparam logic [3:0] TYPE_GATED    = 4'ha;
   localparam logic [3:0] TYPE_SPATIAL  = 4'hb;
   localparam logic [3:0] TYPE_POSITION = 4'hc;
   localparam logic [3:0] TYPE_GATE     = 4'hd;
   localparam logic [3:0] TYPE_PERIODIC = 4'he;
   localparam logic [3:0] TYPE_EXT      = 4'hf;

   localparam logic [7:0] EXT_ANALOG    = 8'hf0;
   localparam logic [7:0] EXT_OVERFLOW  = 8'hf1;

   typedef struct packed {
      kind_type                        kind;
      cause_type                       cause;
      logic [3:0]                      err_index;
      logic                            has_time;
      logic [31:0]                     offset;
      logic [NUM_WORDS-1:0][31:0]      words;
   } desc_type;

endpackage

// ===== sv/list_mode_packet_parser_top.sv =====
// ---------------------------------------------------------------------------
// list_mode_packet_parser_top
// List-mode packet parser: byte stream in, one result beat per packet field.
// ---------------------------------------------------------------------------
// The req channel takes one stream byte per beat (req_in_byte). The rsp
// channel gives one beat per packet field, with rsp_last_item on the final
// beat of a packet; errors come as a single beat carrying cause, word and
// stream offset. Both channels move a beat when valid is high and stall low.
// Bytes enter a 44-byte window; the classifier frames one packet per cycle
// from its head while the queue has room and pushes it into a two-entry
// queue. The expander loads a packet and then emits one field per cycle
// while rsp_stall is low; it takes the next packet only after the last
// field of the current one, so that expander sets throughput. With the
// pipe idle, the byte that completes a packet goes from the window through
// the queue and the expander's packet register into the output register.
// req_stall rises only when the window holds 44 bytes. When rsp_stall is
// held, the output register holds its beat, the queue fills, then the
// window fills and req_stall follows. Reset clears window fill, stream
// offset, queue and output valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
module list_mode_packet_parser_top #(
   parameter int QUEUE_DEPTH = lmpp_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_in_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [3:0]   rsp_pkt_kind,
   output logic [1:0]   rsp_error_cause,
   output logic [3:0]   rsp_item_index,
   output logic [31:0]  rsp_item_value,
   output logic [31:0]  rsp_src_offset,
   output logic         rsp_last_item
);

   lmpp_pkg::desc_type  push_data, head;
   logic                push, full, pop, empty;

   lmpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (full),
      .q_push      (push),
      .q_data      (push_data)
   );

   lmpp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   lmpp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_head          (head),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pkt_kind    (rsp_pkt_kind),
      .rsp_error_cause (rsp_error_cause),
      .rsp_item_index  (rsp_item_index),
      .rsp_item_value  (rsp_item_value),
      .rsp_src_offset  (rsp_src_offset),
      .rsp_last_item   (rsp_last_item)
   );

endmodule

// ===== sv/lmpp_front.sv =====
// ---------------------------------------------------------------------------
// lmpp_front
// Byte window and packet classifier: frames one packet per cycle while the queue has room.
// ---------------------------------------------------------------------------
module lmpp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                q_full,
   output logic                q_push,
   output lmpp_pkg::desc_type  q_data
);

   logic [lmpp_pkg::WIN_DEPTH-1:0][7:0]                win_ff, win_in, win_shift;
   logic [lmpp_pkg::FILL_W-1:0]                        fill_ff, fill_in, consume, ins_pos;
   logic [31:0]                                        offset_ff, offset_in;
   logic [lmpp_pkg::NUM_WORDS-1:0][31:0]               words;
   logic [3:0]                                         t;
   logic [3:0]                                         nw;
   logic [lmpp_pkg::FILL_W-1:0]                        need;
   logic [lmpp_pkg::NUM_WORDS-1:0]                     mism;
   logic [7:0]                                         expv;
   logic [3:0]                                         bad_idx;
   logic                                               in_acc;

   assign words     = win_ff;
   assign t         = words[0][31:28];
   assign req_stall = (fill_ff == lmpp_pkg::FILL_W'(lmpp_pkg::WIN_DEPTH));
   assign in_acc    = req_valid && !req_stall;

   // tag check over the long packets
   always_comb begin
      nw = 4'd11;
      if (t == lmpp_pkg::TYPE_POSITION) nw = 4'd7;
      else if (t == lmpp_pkg::TYPE_PERIODIC) nw = 4'd10;
      need = {nw, 2'b00};
      expv = 8'h00;
      for (int i = 0; i < lmpp_pkg::NUM_WORDS; i++) begin
         if (4'(i) == nw - 4'd1) begin
            expv = {t, 4'hf};
         end else if (t == lmpp_pkg::TYPE_PERIODIC) begin
            expv = (i == 0) ? 8'he0 : (8'he0 | 8'(i + 1));
         end else begin
            expv = {t, 4'(i)};
         end
         mism[i] = (4'(i) < nw) && (words[i][31:24] != expv);
      end
      bad_idx = 4'd0;
      for (int i = lmpp_pkg::NUM_WORDS - 1; i >= 0; i--) begin
         if (mism[i]) bad_idx = 4'(i);
      end
   end

   always_comb begin
      consume         = '0;
      q_push          = 1'b0;
      q_data          = '0;
      q_data.offset   = offset_ff;
      q_data.words    = words;
      q_data.kind     = lmpp_pkg::KIND_ERROR;
      q_data.cause    = lmpp_pkg::CAUSE_NONE;
      if (fill_ff >= 6'd4) begin
         case (t)
            lmpp_pkg::TYPE_TIME: begin
               consume = 6'd4;
            end
            lmpp_pkg::TYPE_PULSE: begin
               if (fill_ff >= 6'd8 && !q_full) begin
                  q_push          = 1'b1;
                  q_data.kind     = lmpp_pkg::KIND_PULSE;
                  q_data.has_time = (words[1][31:28] == lmpp_pkg::TYPE_TIME);
                  consume         = q_data.has_time ? 6'd8 : 6'd4;
               end
            end
            lmpp_pkg::TYPE_SYNC: begin
               if (!q_full) begin
                  q_push      = 1'b1;
                  q_data.kind = lmpp_pkg::KIND_SYNC;
                  consume     = 6'd4;
               end
            end
            lmpp_pkg::TYPE_GATE: begin
               if (!q_full) begin
                  q_push      = 1'b1;
                  q_data.kind = lmpp_pkg::KIND_GATE;
                  consume     = 6'd4;
               end
            end
            lmpp_pkg::TYPE_EXT: begin
               if (!q_full) begin
                  q_push = 1'b1;
                  if (words[0][31:24] == lmpp_pkg::EXT_ANALOG) begin
                     q_data.kind = lmpp_pkg::KIND_ANALOG;
                     consume     = 6'd4;
                  end else if (words[0][31:24] == lmpp_pkg::EXT_OVERFLOW) begin
                     q_data.kind = lmpp_pkg::KIND_OVERFLOW;
                     consume     = 6'd4;
                  end else begin
                     q_data.cause = lmpp_pkg::CAUSE_BAD_EXT;
                     consume      = 6'd1;
                  end
               end
            end
            lmpp_pkg::TYPE_GATED, lmpp_pkg::TYPE_SPATIAL,
            lmpp_pkg::TYPE_POSITION, lmpp_pkg::TYPE_PERIODIC: begin
               if (fill_ff >= need && !q_full) begin
                  q_push = 1'b1;
                  if (|mism) begin
                     q_data.cause     = lmpp_pkg::CAUSE_TAG;
                     q_data.err_index = bad_idx;
                     q_data.words[0]  = words[bad_idx];
                     consume          = 6'd1;
                  end else begin
                     case (t)
                        lmpp_pkg::TYPE_GATED:    q_data.kind = lmpp_pkg::KIND_GATED;
                        lmpp_pkg::TYPE_SPATIAL:  q_data.kind = lmpp_pkg::KIND_SPATIAL;
                        lmpp_pkg::TYPE_POSITION: q_data.kind = lmpp_pkg::KIND_POSITION;
                        default:                 q_data.kind = lmpp_pkg::KIND_PERIODIC;
                     endcase
                     consume = need;
                  end
               end
            end
            default: begin
               if (!q_full) begin
                  q_push       = 1'b1;
                  q_data.cause = lmpp_pkg::CAUSE_BAD_TYPE;
                  consume      = 6'd1;
               end
            end
         endcase
      end
   end

   // drop consumed bytes, append the new beat behind the survivors
   always_comb begin
      win_shift = win_ff >> {consume, 3'b000};
      ins_pos   = fill_ff - consume;
      win_in    = win_shift;
      for (int j = 0; j < lmpp_pkg::WIN_DEPTH; j++) begin
         if (in_acc && ins_pos == lmpp_pkg::FILL_W'(j)) win_in[j] = req_in_byte;
      end
      fill_in   = fill_ff - consume + lmpp_pkg::FILL_W'(in_acc);
      offset_in = offset_ff + 32'(consume);
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff   <= '0;
         offset_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         offset_ff <= offset_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lmpp_pkg::FILL_W'(lmpp_pkg::WIN_DEPTH))
      else $error("window fill out of range");
   a_consume_avail: assert property (@(posedge clock) disable iff (reset)
      consume <= fill_ff)
      else $error("consumed more bytes than present");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

endmodule

// ===== sv/lmpp_queue.sv =====
// ---------------------------------------------------------------------------
// lmpp_queue
// Short packet queue between the classifier and the item expander.
// ---------------------------------------------------------------------------
module lmpp_queue #(
   parameter int DEPTH = lmpp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lmpp_pkg::desc_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output lmpp_pkg::desc_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lmpp_pkg::desc_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ===== sv/lmpp_back.sv =====
// ---------------------------------------------------------------------------
// lmpp_back
// Item expander: turns one framed packet into its result beats.
// ---------------------------------------------------------------------------
module lmpp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  lmpp_pkg::desc_type  q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_pkt_kind,
   output logic [1:0]          rsp_error_cause,
   output logic [3:0]          rsp_item_index,
   output logic [31:0]         rsp_item_value,
   output logic [31:0]         rsp_src_offset,
   output logic                rsp_last_item
);

   lmpp_pkg::desc_type  cur_ff, cur_in;
   logic                busy_ff, busy_in;
   logic [3:0]          idx_ff, idx_in;
   logic                ov_ff, ov_in;
   logic [3:0]          kind_ff, idx_out_ff;
   logic [1:0]          cause_ff;
   logic [31:0]         val_ff, off_ff;
   logic                last_ff;
   logic [3:0]          count, widx;
   logic [31:0]         wsel, value;
   logic                is_last, out_free, load;

   function automatic logic [31:0] sext24(input logic [31:0] v);
      sext24 = {{8{v[23]}}, v[23:0]};
   endfunction

   always_comb begin
      case (cur_ff.kind)
         lmpp_pkg::KIND_PULSE:    count = 4'd5;
         lmpp_pkg::KIND_GATED,
         lmpp_pkg::KIND_SPATIAL,
         lmpp_pkg::KIND_PERIODIC: count = 4'd10;
         lmpp_pkg::KIND_POSITION: count = 4'd7;
         lmpp_pkg::KIND_GATE,
         lmpp_pkg::KIND_ANALOG:   count = 4'd2;
         default:                 count = 4'd1;
      endcase
      is_last = (idx_ff == count - 4'd1);
      widx    = (cur_ff.kind == lmpp_pkg::KIND_GATED || cur_ff.kind == lmpp_pkg::KIND_SPATIAL)
                ? idx_ff + 4'd1 : idx_ff;
      wsel    = (widx < 4'(lmpp_pkg::NUM_WORDS)) ? cur_ff.words[widx] : 32'd0;
   end

   always_comb begin
      value = {8'h00, wsel[23:0]};
      case (cur_ff.kind)
         lmpp_pkg::KIND_ERROR: value = cur_ff.words[0];
         lmpp_pkg::KIND_PULSE: begin
            case (idx_ff)
               4'd0:    value = {31'd0, cur_ff.words[0][27]};
               4'd1:    value = sext24(cur_ff.words[0]);
               4'd2:    value = {31'd0, cur_ff.has_time};
               4'd3:    value = cur_ff.has_time ? {20'd0, cur_ff.words[1][19:8]} : 32'd0;
               default: value = cur_ff.has_time ? {24'd0, cur_ff.words[1][7:0]} : 32'd0;
            endcase
         end
         lmpp_pkg::KIND_GATE: begin
            // both fields come from the single gate word
            if (idx_ff == 4'd0) value = {31'd0, cur_ff.words[0][24]};
            else                value = {8'h00, cur_ff.words[0][23:0]};
         end
         lmpp_pkg::KIND_ANALOG: begin
            value = (idx_ff == 4'd0) ? {31'd0, cur_ff.words[0][19]}
                                     : {31'd0, cur_ff.words[0][18]};
         end
         lmpp_pkg::KIND_GATED, lmpp_pkg::KIND_SPATIAL: begin
            if (idx_ff == 4'd0) value = {cur_ff.words[1][7:0], cur_ff.words[0][23:0]};
         end
         lmpp_pkg::KIND_POSITION: begin
            if (idx_ff != 4'd6) value = sext24(wsel);
         end
         default: value = {8'h00, wsel[23:0]};
      endcase
   end

   assign out_free = !ov_ff || !rsp_stall;
   assign load     = busy_ff && out_free;
   assign q_pop    = !busy_ff && !q_empty;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      ov_in   = ov_ff && rsp_stall;
      if (load) begin
         ov_in = 1'b1;
         if (is_last) busy_in = 1'b0;
         else         idx_in  = idx_ff + 4'd1;
      end
      if (q_pop) begin
         cur_in  = q_head;
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (load) begin
         kind_ff    <= cur_ff.kind;
         cause_ff   <= cur_ff.cause;
         idx_out_ff <= (cur_ff.kind == lmpp_pkg::KIND_ERROR) ? cur_ff.err_index : idx_ff;
         val_ff     <= value;
         off_ff     <= cur_ff.offset;
         last_ff    <= is_last;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_pkt_kind    = kind_ff;
   assign rsp_error_cause = cause_ff;
   assign rsp_item_index  = idx_out_ff;
   assign rsp_item_value  = val_ff;
   assign rsp_src_offset  = off_ff;
   assign rsp_last_item   = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < count)
      else $error("item index past packet length");

endmodule

// ===== tb/list_mode_packet_parser_top_tb.sv =====
// ---------------------------------------------------------------------------
// list_mode_packet_parser_top_tb
// Self-checking bench for the list-mode packet parser.
// ---------------------------------------------------------------------------
// An initial block builds a byte stream from whole packets. It starts with a
// directed set: every packet type, short and timed pulses, stray time words,
// bad types, bad extended types, tag faults and extreme bytes. Random packets
// follow, with noise bytes mixed in. A driver sends the bytes with random
// gaps. The monitor keeps its own copy of the byte window and stream offset,
// decodes each accepted byte into the field beats it should cause, and checks
// every rsp beat in order against them. Both sides idle and stall at random,
// apart from a long stretch where neither does.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module list_mode_packet_parser_top_tb;

   typedef struct {
      lmpp_pkg::kind_type   kind;
      lmpp_pkg::cause_type  cause;
      logic [3:0]           idx;
      logic [31:0]          val;
      logic [31:0]          off;
      logic                 last;
   } field_beat_type;

   typedef enum int {
      G_PULSE_SHORT, G_PULSE_TIMED, G_STRAY, G_SYNC, G_GATE, G_ANALOG, G_OVERFLOW,
      G_GATED, G_SPATIAL, G_POSITION, G_PERIODIC, G_BAD_TYPE, G_BAD_EXT, G_NOISE,
      G_COUNT
   } pkt_gen_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_pkt_kind;
   logic [1:0]  rsp_error_cause;
   logic [3:0]  rsp_item_index;
   logic [31:0] rsp_item_value;
   logic [31:0] rsp_src_offset;
   logic        rsp_last_item;

   logic [7:0]     stream_q[$];
   logic [7:0]     win_q[$];
   logic [31:0]    win_offset = 32'd0;
   field_beat_type fields_due[$];
   int             errors = 0;
   int             bytes_sent = 0;
   int             beats_seen = 0;
   int             kind_seen[16];
   int unsigned    cyc = 0;

   list_mode_packet_parser_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pkt_kind(rsp_pkt_kind), .rsp_error_cause(rsp_error_cause),
      .rsp_item_index(rsp_item_index), .rsp_item_value(rsp_item_value),
      .rsp_src_offset(rsp_src_offset), .rsp_last_item(rsp_last_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- stream builder ----------------
   task automatic put_word(input logic [31:0] w);
      stream_q.push_back(w[7:0]);
      stream_q.push_back(w[15:8]);
      stream_q.push_back(w[23:16]);
      stream_q.push_back(w[31:24]);
   endtask

   function automatic logic [7:0] stats_tag(logic [3:0] t, int i, int nw);
      if (i == nw - 1) return {t, 4'hf};
      if (t == lmpp_pkg::TYPE_PERIODIC) return (i == 0) ? 8'he0 : (8'he0 | 8'(i + 1));
      return {t, 4'(i)};
   endfunction

   task automatic put_tagged(input logic [3:0] t, input bit corrupt);
      int          nw;
      int          bad;
      logic [7:0]  tag;
      nw  = (t == lmpp_pkg::TYPE_POSITION) ? 7 : ((t == lmpp_pkg::TYPE_PERIODIC) ? 10 : 11);
      bad = corrupt ? $urandom_range(nw - 1) : -1;
      for (int i = 0; i < nw; i++) begin
         tag = stats_tag(t, i, nw);
         if (i == bad) tag = tag ^ 8'($urandom_range(255, 1));
         put_word({tag, 24'($urandom)});
      end
   endtask

   task automatic put_packet(input pkt_gen_type g, input bit corrupt);
      logic [3:0] bt;
      case (g)
         G_PULSE_SHORT: put_word({lmpp_pkg::TYPE_PULSE, 28'($urandom)});
         G_PULSE_TIMED: begin
            put_word({lmpp_pkg::TYPE_PULSE, 28'($urandom)});
            put_word({lmpp_pkg::TYPE_TIME, 28'($urandom)});
         end
         G_STRAY:      put_word({lmpp_pkg::TYPE_TIME, 28'($urandom)});
         G_SYNC:       put_word({lmpp_pkg::TYPE_SYNC, 28'($urandom)});
         G_GATE:       put_word({lmpp_pkg::TYPE_GATE, 28'($urandom)});
         G_ANALOG:     put_word({lmpp_pkg::EXT_ANALOG, 24'($urandom)});
         G_OVERFLOW:   put_word({lmpp_pkg::EXT_OVERFLOW, 24'($urandom)});
         G_GATED:      put_tagged(lmpp_pkg::TYPE_GATED, corrupt);
         G_SPATIAL:    put_tagged(lmpp_pkg::TYPE_SPATIAL, corrupt);
         G_POSITION:   put_tagged(lmpp_pkg::TYPE_POSITION, corrupt);
         G_PERIODIC:   put_tagged(lmpp_pkg::TYPE_PERIODIC, corrupt);
         G_BAD_TYPE: begin
            bt = ($urandom_range(6) == 6) ? 4'h9 : 4'($urandom_range(7, 2));
            put_word({bt, 28'($urandom)});
         end
         G_BAD_EXT:    put_word({8'($urandom_range(255, 8'hf2)), 24'($urandom)});
         default: repeat ($urandom_range(6, 1)) stream_q.push_back(8'($urandom));
      endcase
   endtask

   // ---------------- predictor ----------------
   function automatic logic [31:0] win_word(int i);
      return {win_q[4*i+3], win_q[4*i+2], win_q[4*i+1], win_q[4*i]};
   endfunction

   function automatic logic [31:0] sext24(logic [31:0] v);
      return {{8{v[23]}}, v[23:0]};
   endfunction

   task automatic add_field(input lmpp_pkg::kind_type k, input lmpp_pkg::cause_type c,
                            input int i, input logic [31:0] v, input bit l);
      field_beat_type f;
      f.kind = k; f.cause = c; f.idx = 4'(i); f.val = v; f.off = win_offset; f.last = l;
      fields_due.push_back(f);
   endtask

   task automatic drop_bytes(input int n);
      repeat (n) void'(win_q.pop_front());
      win_offset += 32'(n);
   endtask

   // Push one byte and decode every complete packet at the head of the window.
   task automatic decode_byte(input logic [7:0] b);
      logic [31:0]        w, w2;
      logic [3:0]         t;
      int                 nw, bad;
      bit                 has;
      lmpp_pkg::kind_type k;
      if (win_q.size() < lmpp_pkg::WIN_DEPTH) win_q.push_back(b);
      forever begin
         if (win_q.size() < 4) return;
         w = win_word(0);
         t = w[31:28];
         if (t == lmpp_pkg::TYPE_TIME) begin
            drop_bytes(4);
         end else if (t == lmpp_pkg::TYPE_PULSE) begin
            if (win_q.size() < 8) return;
            w2  = win_word(1);
            has = (w2[31:28] == lmpp_pkg::TYPE_TIME);
            add_field(lmpp_pkg::KIND_PULSE, lmpp_pkg::CAUSE_NONE, 0, 32'(w[27]), 0);
            add_field(lmpp_pkg::KIND_PULSE, lmpp_pkg::CAUSE_NONE, 1, sext24(w), 0);
            add_field(lmpp_pkg::KIND_PULSE, lmpp_pkg::CAUSE_NONE, 2, 32'(has), 0);
            add_field(lmpp_pkg::KIND_PULSE, lmpp_pkg::CAUSE_NONE, 3,
                      has ? 32'(w2[19:8]) : 32'd0, 0);
            add_field(lmpp_pkg::KIND_PULSE, lmpp_pkg::CAUSE_NONE, 4,
                      has ? 32'(w2[7:0]) : 32'd0, 1);
            drop_bytes(has ? 8 : 4);
         end else if (t == lmpp_pkg::TYPE_SYNC) begin
            add_field(lmpp_pkg::KIND_SYNC, lmpp_pkg::CAUSE_NONE, 0, {8'd0, w[23:0]}, 1);
            drop_bytes(4);
         end else if (t == lmpp_pkg::TYPE_GATE) begin
            add_field(lmpp_pkg::KIND_GATE, lmpp_pkg::CAUSE_NONE, 0, 32'(w[24]), 0);
            add_field(lmpp_pkg::KIND_GATE, lmpp_pkg::CAUSE_NONE, 1, {8'd0, w[23:0]}, 1);
            drop_bytes(4);
         end else if (t == lmpp_pkg::TYPE_EXT) begin
            if (w[31:24] == lmpp_pkg::EXT_ANALOG) begin
               add_field(lmpp_pkg::KIND_ANALOG, lmpp_pkg::CAUSE_NONE, 0, 32'(w[19]), 0);
               add_field(lmpp_pkg::KIND_ANALOG, lmpp_pkg::CAUSE_NONE, 1, 32'(w[18]), 1);
               drop_bytes(4);
            end else if (w[31:24] == lmpp_pkg::EXT_OVERFLOW) begin
               add_field(lmpp_pkg::KIND_OVERFLOW, lmpp_pkg::CAUSE_NONE, 0,
                         {8'd0, w[23:0]}, 1);
               drop_bytes(4);
            end else begin
               add_field(lmpp_pkg::KIND_ERROR, lmpp_pkg::CAUSE_BAD_EXT, 0, w, 1);
               drop_bytes(1);
            end
         end else if (t == lmpp_pkg::TYPE_GATED || t == lmpp_pkg::TYPE_SPATIAL ||
                      t == lmpp_pkg::TYPE_POSITION || t == lmpp_pkg::TYPE_PERIODIC) begin
            nw = (t == lmpp_pkg::TYPE_POSITION) ? 7 :
                 ((t == lmpp_pkg::TYPE_PERIODIC) ? 10 : 11);
            if (win_q.size() < nw * 4) return;
            bad = nw;
            for (int i = nw - 1; i >= 0; i--)
               if (win_word(i)[31:24] != stats_tag(t, i, nw)) bad = i;
            if (bad < nw) begin
               add_field(lmpp_pkg::KIND_ERROR, lmpp_pkg::CAUSE_TAG, bad, win_word(bad), 1);
               drop_bytes(1);
            end else begin
               if (t == lmpp_pkg::TYPE_POSITION) begin
                  for (int i = 0; i < 6; i++)
                     add_field(lmpp_pkg::KIND_POSITION, lmpp_pkg::CAUSE_NONE, i,
                               sext24(win_word(i)), 0);
                  add_field(lmpp_pkg::KIND_POSITION, lmpp_pkg::CAUSE_NONE, 6,
                            {8'd0, win_word(6)[23:0]}, 1);
               end else if (t == lmpp_pkg::TYPE_PERIODIC) begin
                  for (int i = 0; i < 10; i++)
                     add_field(lmpp_pkg::KIND_PERIODIC, lmpp_pkg::CAUSE_NONE, i,
                               {8'd0, win_word(i)[23:0]}, i == 9);
               end else begin
                  k = (t == lmpp_pkg::TYPE_GATED) ? lmpp_pkg::KIND_GATED
                                                  : lmpp_pkg::KIND_SPATIAL;
                  add_field(k, lmpp_pkg::CAUSE_NONE, 0, {win_word(1)[7:0], w[23:0]}, 0);
                  for (int i = 1; i < 10; i++)
                     add_field(k, lmpp_pkg::CAUSE_NONE, i, {8'd0, win_word(i + 1)[23:0]},
                               i == 9);
               end
               drop_bytes(nw * 4);
            end
         end else begin
            add_field(lmpp_pkg::KIND_ERROR, lmpp_pkg::CAUSE_BAD_TYPE, 0, w, 1);
            drop_bytes(1);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch at beat %0d: %s got %h want %h", beats_seen, what, got, want);
   endtask

   // ---------------- idling ----------------
   // No idling or stalls in a long quiet stretch at the start of each period.
   function automatic bit take_gap();
      if ((cyc % 6000) < 1500) return 1'b0;
      return $urandom_range(99) < 24;
   endfunction

   always @(posedge clock) cyc <= cyc + 1;

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= take_gap();
   end

   // driver: advance only when the current beat is taken or none is held
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (stream_q.size() != 0 && !take_gap()) begin
            req_valid   <= 1'b1;
            req_in_byte <= stream_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict accepted bytes, then check the rsp beat
   always @(posedge clock) begin
      field_beat_type f;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_in_byte);
            bytes_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            kind_seen[rsp_pkt_kind]++;
            if (fields_due.size() == 0) begin
               report_mismatch("unexpected beat, kind", 32'(rsp_pkt_kind), 32'd0);
            end else begin
               f = fields_due.pop_front();
               if (rsp_pkt_kind != f.kind)
                  report_mismatch("pkt_kind", 32'(rsp_pkt_kind), 32'(f.kind));
               if (rsp_error_cause != f.cause)
                  report_mismatch("error_cause", 32'(rsp_error_cause), 32'(f.cause));
               if (rsp_item_index != f.idx)
                  report_mismatch("item_index", 32'(rsp_item_index), 32'(f.idx));
               if (rsp_item_value != f.val)
                  report_mismatch("item_value", rsp_item_value, f.val);
               if (rsp_src_offset != f.off)
                  report_mismatch("src_offset", rsp_src_offset, f.off);
               if (rsp_last_item != f.last)
                  report_mismatch("last_item", 32'(rsp_last_item), 32'(f.last));
            end
         end
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      pkt_gen_type g;
      int          r;
      // directed: extreme bytes first, then every packet form
      put_word(32'h00000000);
      put_word(32'h0fffffff);
      put_word(32'h1fffffff);
      put_word(32'h10000000);
      put_word(32'h8fffffff);
      put_word(32'hdfffffff);
      put_word(32'hf0ffffff);
      put_word(32'hf1000000);
      put_word(32'hffffffff);
      for (int i = 0; i < G_COUNT; i++) put_packet(pkt_gen_type'(i), 1'b0);
      put_packet(G_GATED, 1'b1);
      put_packet(G_POSITION, 1'b1);
      put_packet(G_PERIODIC, 1'b1);
      put_packet(G_SPATIAL, 1'b1);
      put_packet(G_PULSE_SHORT, 1'b0);
      put_packet(G_STRAY, 1'b0);
      // random: mostly well-formed packets, some noise and broken ones
      while (stream_q.size() < 480) begin
         r = $urandom_range(99);
         if (r < 80) g = pkt_gen_type'($urandom_range(G_PERIODIC));
         else if (r < 88) g = pkt_gen_type'($urandom_range(G_PERIODIC, G_GATED));
         else g = pkt_gen_type'($urandom_range(G_NOISE, G_BAD_TYPE));
         put_packet(g, r >= 80 && r < 88);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (stream_q.size() != 0 || req_valid) @(posedge clock);
      while (fields_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fields_due.size() != 0) errors++;
      $display("run covered %0d bytes and %0d result beats: %0d pulse, %0d error,",
               bytes_sent, beats_seen, kind_seen[lmpp_pkg::KIND_PULSE],
               kind_seen[lmpp_pkg::KIND_ERROR]);
      $display("  %0d stats, %0d position, %0d periodic field beats",
               kind_seen[lmpp_pkg::KIND_GATED] + kind_seen[lmpp_pkg::KIND_SPATIAL],
               kind_seen[lmpp_pkg::KIND_POSITION], kind_seen[lmpp_pkg::KIND_PERIODIC]);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
